[rtl/mmch_pkg.sv]
// ----------------------------------------------------------------------------
// mmch_pkg: shared types and constants for the magnetometer calibration block
// Holds operation codes, controller states, command/status structs and the
// CORDIC arctangent table in units of 2^-16 degree.
// ----------------------------------------------------------------------------
package mmch_pkg;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_FINISH  = 2'd2,
        OP_MEASURE = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL,
        ST_COR_START,
        ST_COR_WAIT,
        ST_OUT
    } state_t;

    localparam int AXES        = 3;
    localparam int ATAN_LEN    = 24;
    localparam int RAW_W       = 16;
    localparam int CAL_W       = 25;
    localparam int DIV_W       = 34;
    localparam int COR_W       = 40;
    localparam int ANG_W       = 32;

    typedef struct packed {
        logic       load;       // latch the input request
        logic       update;     // perform start/sample update on latched axis
        logic       div_go;     // launch divider for current axis
        logic       div_store;  // store scale for current axis
        logic       mul;        // measure multiply for current axis
        logic       cor_go;     // launch CORDIC
        logic       axis_clr;
        logic       axis_inc;
    } cmd_t;

    typedef struct packed {
        op_t        op;
        logic       bad;        // sensor out of range or measure overflow
        logic       div_done;
        logic       cor_done;
        logic       last_axis;
    } sts_t;

    function automatic logic [ANG_W-1:0] atan_deg16(input logic [4:0] i);
        case (i)
            5'd0:  atan_deg16 = 32'd2949120;
            5'd1:  atan_deg16 = 32'd1740967;
            5'd2:  atan_deg16 = 32'd919879;
            5'd3:  atan_deg16 = 32'd466945;
            5'd4:  atan_deg16 = 32'd234379;
            5'd5:  atan_deg16 = 32'd117304;
            5'd6:  atan_deg16 = 32'd58666;
            5'd7:  atan_deg16 = 32'd29335;
            5'd8:  atan_deg16 = 32'd14668;
            5'd9:  atan_deg16 = 32'd7334;
            5'd10: atan_deg16 = 32'd3667;
            5'd11: atan_deg16 = 32'd1833;
            5'd12: atan_deg16 = 32'd917;
            5'd13: atan_deg16 = 32'd458;
            5'd14: atan_deg16 = 32'd229;
            5'd15: atan_deg16 = 32'd115;
            5'd16: atan_deg16 = 32'd57;
            5'd17: atan_deg16 = 32'd29;
            5'd18: atan_deg16 = 32'd14;
            5'd19: atan_deg16 = 32'd7;
            5'd20: atan_deg16 = 32'd4;
            5'd21: atan_deg16 = 32'd2;
            5'd22: atan_deg16 = 32'd1;
            default: atan_deg16 = 32'd0;
        endcase
    endfunction

endpackage

[rtl/mag_minmax_calibration_heading.sv]
// ----------------------------------------------------------------------------
// mag_minmax_calibration_heading: magnetometer min/max calibration and heading
// Tracks per-axis extremes, derives offset and scale, and outputs calibrated
// Q20.4 vectors with a CORDIC azimuth.
// ----------------------------------------------------------------------------
// Sequencing: start/sample update the axes in turn; finish runs the bit-serial
//   divider once per axis; measure multiplies the axes, then runs the
//   one-rotation-per-cycle CORDIC, which stops early when the rotation ends;
//   an out-of-range sensor or measure overflow goes straight to the result.
// Throughput: one request at a time; the next request can be taken in the cycle
//   after the one that loads the result register.
// Reset: all mins, maxes and offsets clear to zero, every scale to 1.0.
module mag_minmax_calibration_heading #(
    parameter int NUM_SENSORS     = 2,
    parameter int SCALE_FRAC_BITS = 12,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], sensor[2], mag_x[18:3], mag_y[34:19], mag_z[50:35], pad
    input  logic [55:0]  s_tdata,
    // overflow
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cal_x[24:0], cal_y[49:25], cal_z[74:50], azimuth[83:75],
    // sample_valid[84], range_error[85], pad
    output logic [87:0]  m_tdata
);
    mmch_pkg::cmd_t cmd;
    mmch_pkg::sts_t sts;
    logic           in_ready, out_set, out_free;
    logic           m_valid_reg;
    logic [85:0]    m_data_reg;
    logic signed [24:0] cx, cy, cz;
    logic [8:0]     az;
    logic           sv, re;

    // result register frees once its request has been taken
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = in_ready;

    mmch_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (s_tvalid && in_ready),
        .out_free(out_free),
        .sts     (sts),
        .cmd     (cmd),
        .in_ready(in_ready),
        .out_set (out_set)
    );

    mmch_dp #(
        .NUM_SENSORS    (NUM_SENSORS),
        .SCALE_FRAC_BITS(SCALE_FRAC_BITS),
        .CORDIC_STEPS   (CORDIC_STEPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (s_tdata[1:0]),
        .sensor      (s_tdata[2]),
        .mag_x       (s_tdata[18:3]),
        .mag_y       (s_tdata[34:19]),
        .mag_z       (s_tdata[50:35]),
        .overflow    (s_tuser),
        .sts         (sts),
        .cal_x       (cx),
        .cal_y       (cy),
        .cal_z       (cz),
        .azimuth     (az),
        .sample_valid(sv),
        .range_error (re)
    );

    // hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_set)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_set)
            m_data_reg <= {re, sv, az, cz, cy, cx};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    // a new request is never taken while an update is in progress
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !s_tready)
        else $error("request accepted during update");
    // a result loads only when the output slot is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_set |-> (!m_valid_reg || m_tready))
        else $error("result overwrote pending output");
    // divider and cordic are never launched together
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.div_go && cmd.cor_go))
        else $error("two units launched");
endmodule

[rtl/mmch_div.sv]
// ----------------------------------------------------------------------------
// mmch_div: restoring unsigned divider, one quotient bit per cycle
// Computes num / den; den must be nonzero.
// ----------------------------------------------------------------------------
module mmch_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [mmch_pkg::DIV_W-1:0]  num,
    input  logic [mmch_pkg::DIV_W-1:0]  den,
    output logic                        done,
    output logic [mmch_pkg::DIV_W-1:0]  quo
);
    localparam int CW = $clog2(mmch_pkg::DIV_W + 1);

    logic [mmch_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [mmch_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [mmch_pkg::DIV_W-1:0] den_reg, den_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [mmch_pkg::DIV_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[mmch_pkg::DIV_W-1]};
        if (go)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CW'(mmch_pkg::DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one numerator bit, subtract when it fits
            if (trial >= {1'b0, den_reg})
            begin
                trial    = trial - {1'b0, den_reg};
                quo_next = {quo_reg[mmch_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[mmch_pkg::DIV_W-2:0], 1'b0};
            end
            rem_next = trial[mmch_pkg::DIV_W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

[rtl/mmch_cordic.sv]
// ----------------------------------------------------------------------------
// mmch_cordic: vectoring CORDIC, one rotation per cycle
// Produces the whole-degree heading of (x, y), 0..359.
// ----------------------------------------------------------------------------
module mmch_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  logic signed [mmch_pkg::CAL_W-1:0]   cx,
    input  logic signed [mmch_pkg::CAL_W-1:0]   cy,
    output logic                                done,
    output logic [8:0]                          deg
);
    localparam int W = mmch_pkg::COR_W;
    localparam int A = mmch_pkg::ANG_W;

    logic signed [W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [A-1:0] z_reg, z_next;
    logic [4:0]          i_reg, i_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic signed [W-1:0] xs, ys, x0, y0;
    logic signed [A-1:0] zq;
    logic signed [A-1:0] dz;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        x0 = W'(cx) <<< 8;
        y0 = W'(cy) <<< 8;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        if (go)
        begin
            i_next = '0;
            if (cx == '0)
            begin
                x_next = '0;
                y_next = '0;
                z_next = (cy == '0) ? '0 : ((cy > 0) ? A'(90 * 65536) : -A'(90 * 65536));
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (cx < 0)
            begin
                x_next = -x0;
                y_next = -y0;
                z_next = (cy >= 0) ? A'(180 * 65536) : -A'(180 * 65536);
                busy_next = 1'b1;
            end
            else
            begin
                x_next = x0;
                y_next = y0;
                z_next = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg == '0 || 32'(i_reg) >= STEPS || i_reg >= 5'(mmch_pkg::ATAN_LEN))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + $signed(mmch_pkg::atan_deg16(i_reg));
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - $signed(mmch_pkg::atan_deg16(i_reg));
                end
                i_next = i_reg + 5'd1;
            end
        end
    end

    // truncate toward zero, wrap negatives by a full turn
    always_comb
    begin
        dz = z_reg >>> 16;
        if (z_reg < 0 && z_reg[15:0] != '0)
            dz = dz + A'(1);
        zq = (dz < 0) ? dz + A'(360) : dz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
    end

    assign done = done_reg;
    assign deg  = zq[8:0];
endmodule

[rtl/mmch_ctrl.sv]
// ----------------------------------------------------------------------------
// mmch_ctrl: sequencing state machine
// Steps through the three axes for each valid request and drives the datapath.
// ----------------------------------------------------------------------------
module mmch_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_free,
    input  mmch_pkg::sts_t    sts,
    output mmch_pkg::cmd_t    cmd,
    output logic              in_ready,
    output logic              out_set
);
    mmch_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmch_pkg::ST_IDLE:      if (in_fire) state_next = mmch_pkg::ST_READ;
            mmch_pkg::ST_READ:
            begin
                if (sts.bad)
                    state_next = mmch_pkg::ST_OUT;
                else
                begin
                    unique case (sts.op)
                        mmch_pkg::OP_FINISH:  state_next = mmch_pkg::ST_DIV_START;
                        mmch_pkg::OP_MEASURE: state_next = mmch_pkg::ST_MUL;
                        default:              state_next = mmch_pkg::ST_UPDATE;
                    endcase
                end
            end
            mmch_pkg::ST_UPDATE:    if (sts.last_axis) state_next = mmch_pkg::ST_OUT;
            mmch_pkg::ST_DIV_START: state_next = mmch_pkg::ST_DIV_WAIT;
            mmch_pkg::ST_DIV_WAIT:
                if (sts.div_done)
                    state_next = sts.last_axis ? mmch_pkg::ST_OUT : mmch_pkg::ST_DIV_START;
            mmch_pkg::ST_MUL:       if (sts.last_axis) state_next = mmch_pkg::ST_COR_START;
            mmch_pkg::ST_COR_START: state_next = mmch_pkg::ST_COR_WAIT;
            mmch_pkg::ST_COR_WAIT:  if (sts.cor_done) state_next = mmch_pkg::ST_OUT;
            mmch_pkg::ST_OUT:       if (out_free) state_next = mmch_pkg::ST_IDLE;
            default:                state_next = mmch_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        out_set  = 1'b0;
        unique case (state_reg)
            mmch_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load     = 1'b1;
                cmd.axis_clr = 1'b1;
            end
            mmch_pkg::ST_READ:      cmd.axis_clr = 1'b1;
            mmch_pkg::ST_UPDATE:
            begin
                cmd.update   = 1'b1;
                cmd.axis_inc = 1'b1;
            end
            mmch_pkg::ST_DIV_START: cmd.div_go = 1'b1;
            mmch_pkg::ST_DIV_WAIT:
            begin
                cmd.div_store = sts.div_done;
                cmd.axis_inc  = sts.div_done;
            end
            mmch_pkg::ST_MUL:
            begin
                cmd.mul      = 1'b1;
                cmd.axis_inc = 1'b1;
            end
            mmch_pkg::ST_COR_START: cmd.cor_go = 1'b1;
            mmch_pkg::ST_COR_WAIT:  ;
            mmch_pkg::ST_OUT:       out_set = out_free;
            default:                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mmch_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

[rtl/mmch_dp.sv]
// ----------------------------------------------------------------------------
// mmch_dp: calibration datapath
// Holds per-axis min/max/offset/scale registers, the scale divider, the
// measure multiplier and the heading CORDIC.
// ----------------------------------------------------------------------------
module mmch_dp #(
    parameter int NUM_SENSORS     = 2,
    parameter int SCALE_FRAC_BITS = 12,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mmch_pkg::cmd_t                      cmd,
    input  logic [1:0]                          operation,
    input  logic                                sensor,
    input  logic signed [15:0]                  mag_x,
    input  logic signed [15:0]                  mag_y,
    input  logic signed [15:0]                  mag_z,
    input  logic                                overflow,
    output mmch_pkg::sts_t                      sts,
    output logic signed [mmch_pkg::CAL_W-1:0]   cal_x,
    output logic signed [mmch_pkg::CAL_W-1:0]   cal_y,
    output logic signed [mmch_pkg::CAL_W-1:0]   cal_z,
    output logic [8:0]                          azimuth,
    output logic                                sample_valid,
    output logic                                range_error
);
    localparam int NE = NUM_SENSORS * mmch_pkg::AXES;
    localparam int EW = (NE > 1) ? $clog2(NE) : 1;
    localparam int SHR = SCALE_FRAC_BITS - 3;
    localparam int CAL_MAX = (1 << 24) - 1;
    localparam int CAL_MIN = -(1 << 24);

    logic signed [15:0] axis_min_reg [NE];
    logic signed [15:0] axis_max_reg [NE];
    logic signed [16:0] axis_off_reg [NE];
    logic [15:0]        axis_scale_reg [NE];

    logic [1:0]         op_reg;
    logic               sensor_reg;
    logic               ovf_reg;
    logic signed [15:0] raw_reg [mmch_pkg::AXES];
    logic [1:0]         axis_reg, axis_next;
    logic               err_reg;
    logic [18:0]        span_sum;
    logic signed [mmch_pkg::CAL_W-1:0] cal_reg [mmch_pkg::AXES];

    logic [EW-1:0]      ent;
    logic signed [15:0] cur_raw, cur_min, cur_max;
    logic [16:0]        span;
    logic               sensor_ok;
    logic [mmch_pkg::DIV_W-1:0] div_quo;
    logic               div_done, cor_done;
    logic signed [17:0] diff;
    logic signed [34:0] prod;
    logic signed [34:0] shr;
    logic [8:0]         cor_deg;

    assign sensor_ok = 32'(sensor_reg) < NUM_SENSORS;
    assign ent       = EW'(32'(sensor_reg) * mmch_pkg::AXES + 32'(axis_reg));
    assign cur_raw   = raw_reg[axis_reg];
    assign cur_min   = axis_min_reg[ent];
    assign cur_max   = axis_max_reg[ent];
    assign span      = 17'($signed({cur_max[15], cur_max}) - $signed({cur_min[15], cur_min}));

    assign axis_next = cmd.axis_clr ? 2'd0 : (cmd.axis_inc ? axis_reg + 2'd1 : axis_reg);

    // span total of all three axes, for the sensor in hand
    always_comb
    begin
        span_sum = '0;
        for (int a = 0; a < mmch_pkg::AXES; a++)
            span_sum = span_sum + 19'($signed({axis_max_reg[EW'(32'(sensor_reg) * 3 + a)][15],
                       axis_max_reg[EW'(32'(sensor_reg) * 3 + a)]})
                       - $signed({axis_min_reg[EW'(32'(sensor_reg) * 3 + a)][15],
                       axis_min_reg[EW'(32'(sensor_reg) * 3 + a)]}));
    end

    mmch_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (cmd.div_go),
        .num  (mmch_pkg::DIV_W'({15'd0, span_sum} << SCALE_FRAC_BITS)),
        .den  (mmch_pkg::DIV_W'(span) * mmch_pkg::DIV_W'(3) | mmch_pkg::DIV_W'(span == '0)),
        .done (div_done),
        .quo  (div_quo)
    );

    assign diff = 18'(cur_raw) * 18'sd2 - 18'(axis_off_reg[ent]);
    assign prod = 35'(diff) * $signed({19'd0, axis_scale_reg[ent]});
    assign shr  = prod >>> SHR;

    mmch_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (cmd.cor_go),
        .cx   (cal_reg[0]),
        .cy   (cal_reg[1]),
        .done (cor_done),
        .deg  (cor_deg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < NE; e++)
            begin
                axis_min_reg[e]   <= '0;
                axis_max_reg[e]   <= '0;
                axis_off_reg[e]   <= '0;
                axis_scale_reg[e] <= 16'(1 << SCALE_FRAC_BITS);
            end
            axis_reg <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            axis_reg <= axis_next;
            if (cmd.load)
                err_reg <= 1'b0;
            if (cmd.update)
            begin
                if (op_reg == mmch_pkg::OP_START)
                begin
                    axis_min_reg[ent] <= '0;
                    axis_max_reg[ent] <= '0;
                end
                else if (!ovf_reg)
                begin
                    if (cur_raw < cur_min) axis_min_reg[ent] <= cur_raw;
                    if (cur_raw > cur_max) axis_max_reg[ent] <= cur_raw;
                end
            end
            if (cmd.div_store)
            begin
                axis_off_reg[ent] <= 17'(cur_max) + 17'(cur_min);
                if (span == '0)
                begin
                    axis_scale_reg[ent] <= 16'hFFFF;
                    err_reg             <= 1'b1;
                end
                else
                    axis_scale_reg[ent] <= (div_quo > 34'hFFFF) ? 16'hFFFF : div_quo[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            sensor_reg <= sensor;
            ovf_reg    <= overflow;
            raw_reg[0] <= mag_x;
            raw_reg[1] <= mag_y;
            raw_reg[2] <= mag_z;
        end
        if (cmd.mul)
        begin
            if (shr > 35'(CAL_MAX))
                cal_reg[axis_reg] <= mmch_pkg::CAL_W'(CAL_MAX);
            else if (shr < 35'(CAL_MIN))
                cal_reg[axis_reg] <= mmch_pkg::CAL_W'(CAL_MIN);
            else
                cal_reg[axis_reg] <= shr[mmch_pkg::CAL_W-1:0];
        end
    end

    assign sts.op        = mmch_pkg::op_t'(op_reg);
    assign sts.bad       = !sensor_ok || (op_reg == mmch_pkg::OP_MEASURE && ovf_reg);
    assign sts.div_done  = div_done;
    assign sts.cor_done  = cor_done;
    assign sts.last_axis = axis_reg == 2'd2;

    // result fields, zero outside their own operation or when the request is bad
    always_comb
    begin
        cal_x        = '0;
        cal_y        = '0;
        cal_z        = '0;
        azimuth      = '0;
        sample_valid = 1'b0;
        range_error  = 1'b0;
        if (!sts.bad)
        begin
            if (op_reg == mmch_pkg::OP_MEASURE)
            begin
                cal_x        = cal_reg[0];
                cal_y        = cal_reg[1];
                cal_z        = cal_reg[2];
                azimuth      = cor_deg;
                sample_valid = 1'b1;
            end
            else if (op_reg == mmch_pkg::OP_FINISH)
                range_error = err_reg;
        end
    end
endmodule
